// File: hw/rtl/header_length_tail_deframer_macros.svh
// Assertion macros for the header/length/tail deframer
`ifndef HEADER_LENGTH_TAIL_DEFRAMER_MACROS_SVH
`define HEADER_LENGTH_TAIL_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define HLTD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define HLTD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/hltd_pkg.sv
// Types, constants and helpers shared by the deframer files
package hltd_pkg;

	localparam int CAND_DEPTH = 512;
	localparam int OUT_DEPTH  = 1024;

	localparam int CAND_AW = $clog2(CAND_DEPTH);
	localparam int CAND_CW = $clog2(CAND_DEPTH + 1);
	localparam int OUT_AW  = $clog2(OUT_DEPTH);
	localparam int OUT_LW  = $clog2(OUT_DEPTH + 1);

	localparam int BYTE_W    = 8;
	localparam int OUT_W     = BYTE_W + 1;
	localparam int QLEVEL_W  = 11;
	localparam int LEN_W     = 9;
	localparam int LEN_OFS   = 3;
	localparam int FRAME_OVH = 6;
	localparam int MIN_CAND  = 6;
	localparam int MAX_FRAME = FRAME_OVH + 255;

	localparam logic [BYTE_W-1:0] HDR_RESET  = 8'hAA;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER = 1'b0,
		CFG_TAIL   = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_TAIL,
		ST_COPY,
		ST_COPY_END,
		ST_ALIGN_RD,
		ST_ALIGN_CMP,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] rx_byte;
	} req_item_t;

	typedef struct packed {
		logic                out_valid;
		logic [BYTE_W-1:0]   out_byte;
		logic                out_last;
		logic                frame_dropped;
		logic [QLEVEL_W-1:0] queue_level;
	} rsp_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic [BYTE_W-1:0] tail_byte;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [CAND_AW-1:0] waddr;
		logic [BYTE_W-1:0]  wdata;
		logic               re;
		logic [CAND_AW-1:0] raddr;
	} cand_port_t;

	typedef struct packed {
		logic              we;
		logic [OUT_AW-1:0] waddr;
		logic [OUT_W-1:0]  wdata;
		logic              re;
		logic [OUT_AW-1:0] raddr;
	} oq_port_t;

	typedef struct packed {
		logic               idle;
		logic [OUT_LW-1:0]  level;
		logic [CAND_CW-1:0] count;
	} seq_status_t;

	// Circular add inside the candidate buffer; both operands below CAND_DEPTH
	function automatic logic [CAND_AW-1:0] cand_add(input logic [CAND_AW-1:0] a,
		input logic [CAND_AW-1:0] b);
		logic [CAND_AW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (CAND_AW+1)'(CAND_DEPTH)) begin
			sum = sum - (CAND_AW+1)'(CAND_DEPTH);
		end
		return sum[CAND_AW-1:0];
	endfunction

	function automatic logic [OUT_AW-1:0] out_inc(input logic [OUT_AW-1:0] p);
		return (p == OUT_AW'(OUT_DEPTH - 1)) ? '0 : p + OUT_AW'(1);
	endfunction

endpackage

// File: hw/rtl/hltd_stream_if.sv
// Request and response channel interfaces of the deframer
interface hltd_req_if import hltd_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hltd_rsp_if import hltd_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/hltd_ram.sv
// Generic single-write, single-read RAM with registered read data
module hltd_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/hltd_seq.sv
// Sequencer: candidate buffer walk, frame copy, queue pointers, result register
module hltd_seq import hltd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	hltd_req_if.sink            req,
	hltd_rsp_if.source          rsp,
	output cand_port_t          cand_port,
	input  logic [BYTE_W-1:0]   cand_rdata,
	output oq_port_t            oq_port,
	input  logic [OUT_W-1:0]    oq_rdata,
	output seq_status_t         status
);

	seq_state_t         state_q, state_d;
	logic [CAND_AW-1:0] start_q, start_d;
	logic [CAND_CW-1:0] count_q, count_d;
	logic [OUT_AW-1:0]  head_q, head_d;
	logic [OUT_AW-1:0]  tail_q, tail_d;
	logic [OUT_LW-1:0]  level_q, level_d;
	logic               rsp_valid_q, rsp_valid_d;
	logic               cp_vld_s1, cp_vld_d;

	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   idx_q, idx_d;
	logic               dropped_q, dropped_d;
	logic               hit_q, hit_d;
	logic               cp_last_s1, cp_last_d;
	rsp_item_t          rsp_q, rsp_d;

	logic               keep;
	logic [CAND_CW-1:0] cnt_new;
	logic [LEN_W-1:0]   len_w;
	logic [OUT_LW:0]    fit_sum;

	always_comb begin
		state_d     = state_q;
		start_d     = start_q;
		count_d     = count_q;
		head_d      = head_q;
		tail_d      = tail_q;
		level_d     = level_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		cp_vld_d    = 1'b0;
		len_d       = len_q;
		idx_d       = idx_q;
		dropped_d   = dropped_q;
		hit_d       = hit_q;
		cp_last_d   = 1'b0;
		rsp_d       = rsp_q;
		req.ready   = 1'b0;
		cand_port   = '0;
		oq_port     = '0;

		keep    = (count_q != '0) || (req.data.rx_byte == cfg.header_byte);
		cnt_new = count_q + CAND_CW'(keep);
		len_w   = LEN_W'(FRAME_OVH) + LEN_W'(cand_rdata);
		fit_sum = (OUT_LW+1)'(level_q) + (OUT_LW+1)'(len_q);

		// Second half of the copy pipeline: candidate byte lands in the queue
		if (cp_vld_s1) begin
			oq_port.we    = 1'b1;
			oq_port.waddr = tail_q;
			oq_port.wdata = {cp_last_s1, cand_rdata};
			tail_d        = out_inc(tail_q);
		end

		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					dropped_d = 1'b0;
					hit_d     = 1'b0;
					state_d   = ST_FIN;
					if (!req.data.func) begin
						if (keep && (count_q < CAND_CW'(CAND_DEPTH))) begin
							cand_port.we    = 1'b1;
							cand_port.waddr = cand_add(start_q, CAND_AW'(count_q));
							cand_port.wdata = req.data.rx_byte;
							count_d         = cnt_new;
						end
						// length byte sits apart from the write slot once six are held
						cand_port.re    = 1'b1;
						cand_port.raddr = cand_add(start_q, CAND_AW'(LEN_OFS));
						if (cnt_new >= CAND_CW'(MIN_CAND)) begin
							state_d = ST_LEN;
						end
					end else if (level_q != '0) begin
						oq_port.re    = 1'b1;
						oq_port.raddr = head_q;
						head_d        = out_inc(head_q);
						level_d       = level_q - OUT_LW'(1);
						hit_d         = 1'b1;
					end
				end
			end
			ST_LEN: begin
				len_d = len_w;
				if (count_q < CAND_CW'(len_w)) begin
					state_d = ST_FIN;
				end else begin
					cand_port.re    = 1'b1;
					cand_port.raddr = cand_add(start_q, CAND_AW'(len_w - LEN_W'(1)));
					state_d         = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (cand_rdata == cfg.tail_byte) begin
					if (fit_sum > (OUT_LW+1)'(OUT_DEPTH)) begin
						dropped_d = 1'b1;
						start_d   = cand_add(start_q, CAND_AW'(len_q));
						count_d   = count_q - CAND_CW'(len_q);
						state_d   = ST_ALIGN_RD;
					end else begin
						idx_d   = '0;
						state_d = ST_COPY;
					end
				end else begin
					// wrong tail: drop the header and rescan
					start_d = cand_add(start_q, CAND_AW'(1));
					count_d = count_q - CAND_CW'(1);
					state_d = ST_ALIGN_RD;
				end
			end
			ST_COPY: begin
				cand_port.re    = 1'b1;
				cand_port.raddr = cand_add(start_q, CAND_AW'(idx_q));
				cp_vld_d        = 1'b1;
				cp_last_d       = (idx_q == len_q - LEN_W'(1));
				idx_d           = idx_q + LEN_W'(1);
				if (cp_last_d) begin
					state_d = ST_COPY_END;
				end
			end
			ST_COPY_END: begin
				start_d = cand_add(start_q, CAND_AW'(len_q));
				count_d = count_q - CAND_CW'(len_q);
				level_d = level_q + OUT_LW'(len_q);
				state_d = ST_ALIGN_RD;
			end
			ST_ALIGN_RD: begin
				if (count_q == '0) begin
					state_d = ST_FIN;
				end else begin
					cand_port.re    = 1'b1;
					cand_port.raddr = start_q;
					state_d         = ST_ALIGN_CMP;
				end
			end
			ST_ALIGN_CMP: begin
				if (cand_rdata == cfg.header_byte) begin
					if (count_q >= CAND_CW'(MIN_CAND)) begin
						cand_port.re    = 1'b1;
						cand_port.raddr = cand_add(start_q, CAND_AW'(LEN_OFS));
						state_d         = ST_LEN;
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					start_d = cand_add(start_q, CAND_AW'(1));
					count_d = count_q - CAND_CW'(1);
					state_d = ST_ALIGN_RD;
				end
			end
			ST_FIN: begin
				// hold until the result register is free
				if (!rsp_valid_q || rsp.ready) begin
					rsp_d.out_valid     = hit_q;
					rsp_d.out_byte      = hit_q ? oq_rdata[BYTE_W-1:0] : '0;
					rsp_d.out_last      = hit_q ? oq_rdata[BYTE_W] : 1'b0;
					rsp_d.frame_dropped = dropped_q;
					rsp_d.queue_level   = QLEVEL_W'(level_q);
					rsp_valid_d         = 1'b1;
					state_d             = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			level_q     <= '0;
			rsp_valid_q <= 1'b0;
			cp_vld_s1   <= 1'b0;
		end else begin
			state_q     <= state_d;
			start_q     <= start_d;
			count_q     <= count_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			level_q     <= level_d;
			rsp_valid_q <= rsp_valid_d;
			cp_vld_s1   <= cp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q      <= len_d;
		idx_q      <= idx_d;
		dropped_q  <= dropped_d;
		hit_q      <= hit_d;
		cp_last_s1 <= cp_last_d;
		rsp_q      <= rsp_d;
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.data     = rsp_q;
	assign status.idle  = (state_q == ST_IDLE);
	assign status.level = level_q;
	assign status.count = count_q;

endmodule

// File: hw/rtl/header_length_tail_deframer.sv
// Top level: frame deframer with candidate buffer RAM and output queue RAM
//
// channel   dir  payload                                              transaction
// req       in   func, rx_byte                                        valid & ready
// rsp       out  out_valid, out_byte, out_last, frame_dropped,        valid & ready
//                queue_level
// cfg       in   cfg_idx, cfg_wdata                                   cfg_we
//
// A pull passes through the final state only; a push does too, or first checks length and tail
// once six or more bytes are buffered. A completed frame that fits is then copied into the queue
// byte by byte. A rescan after a wrong tail reads and compares each skipped byte (one candidate
// RAM read port with registered read data); one item is worked on at a time.
// Both RAMs need no clearing after reset; pointers and counts reset to zero.
// req stalls while an item is in work; a full result register stalls only the end.
`include "header_length_tail_deframer_macros.svh"

module header_length_tail_deframer import hltd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	hltd_req_if.sink             req,
	hltd_rsp_if.source           rsp
);

	cfg_t               cfg_q;
	cand_port_t         cand_port;
	oq_port_t           oq_port;
	logic [BYTE_W-1:0]  cand_rdata;
	logic [OUT_W-1:0]   oq_rdata;
	seq_status_t        seq_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte <= HDR_RESET;
			cfg_q.tail_byte   <= TAIL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_HEADER: cfg_q.header_byte <= cfg_wdata;
				CFG_TAIL:   cfg_q.tail_byte   <= cfg_wdata;
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	hltd_ram #(
		.W     (BYTE_W),
		.DEPTH (CAND_DEPTH)
	) u_cand_ram (
		.clk   (clk),
		.we    (cand_port.we),
		.waddr (cand_port.waddr),
		.wdata (cand_port.wdata),
		.re    (cand_port.re),
		.raddr (cand_port.raddr),
		.rdata (cand_rdata)
	);

	hltd_ram #(
		.W     (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_oq_ram (
		.clk   (clk),
		.we    (oq_port.we),
		.waddr (oq_port.waddr),
		.wdata (oq_port.wdata),
		.re    (oq_port.re),
		.raddr (oq_port.raddr),
		.rdata (oq_rdata)
	);

	hltd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.rsp        (rsp),
		.cand_port  (cand_port),
		.cand_rdata (cand_rdata),
		.oq_port    (oq_port),
		.oq_rdata   (oq_rdata),
		.status     (seq_st)
	);

	`HLTD_ASSERT_IMP(a_level_bound, 1'b1, seq_st.level <= OUT_LW'(OUT_DEPTH), "level above depth")
	`HLTD_ASSERT_IMP(a_cand_bound, 1'b1, seq_st.count <= CAND_CW'(MAX_FRAME), "candidate too long")
	`HLTD_ASSERT_NXT(a_item_busy, req.valid && req.ready, !req.ready && !seq_st.idle, "not busy")

endmodule

// File: sim/header_length_tail_deframer_test.sv
// Self-checking testbench for header_length_tail_deframer: directed table, then random frames
module header_length_tail_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hltd_pkg::*;

	localparam bit FUNC_PUSH = 1'b0;
	localparam bit FUNC_PULL = 1'b1;
	localparam int MAX_SHOWN = 10;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_HOLD = 400;
	localparam rsp_item_t NO_RESULT = '0;

	typedef struct packed {
		logic              func;
		logic [BYTE_W-1:0] data;
		logic              typed;
		rsp_item_t         want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [BYTE_W-1:0] cfg_wdata;

	hltd_req_if req_ch ();
	hltd_rsp_if rsp_ch ();

	header_length_tail_deframer uut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_idx,
		.cfg_wdata,
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state
	logic [BYTE_W-1:0] cur_header;
	logic [BYTE_W-1:0] cur_tail;
	logic [BYTE_W-1:0] cand_bytes[$];
	logic [OUT_W-1:0] queued_bytes[$];

	rsp_item_t due_outputs[$];
	rsp_item_t oldest_due;
	int errors = 0;
	int req_idle_pct = 0;
	int rsp_idle_pct = 0;
	int effective_items = 0;
	int drops_seen = 0;
	bit hold_rsp = 1'b0;
	bit random_started = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic rsp_item_t deframe_step(input req_item_t it, output bit active);
		rsp_item_t r;
		int flen;
		logic [OUT_W-1:0] w;
		r = '0;
		active = 1'b0;
		if (it.func == FUNC_PUSH) begin
			if (cand_bytes.size() > 0 || it.rx_byte == cur_header) begin
				active = 1'b1;
				if (cand_bytes.size() < CAND_DEPTH) begin
					cand_bytes.push_back(it.rx_byte);
				end
			end
			while (cand_bytes.size() >= MIN_CAND) begin
				flen = FRAME_OVH + int'(cand_bytes[LEN_OFS]);
				if (cand_bytes.size() < flen) break;
				if (cand_bytes[flen-1] == cur_tail) begin
					if (queued_bytes.size() + flen > OUT_DEPTH) begin
						r.frame_dropped = 1'b1;
					end else begin
						for (int i = 0; i < flen; i++) begin
							queued_bytes.push_back({i == flen - 1, cand_bytes[i]});
						end
					end
					repeat (flen) void'(cand_bytes.pop_front());
				end else begin
					// wrong tail: drop the header and rescan
					void'(cand_bytes.pop_front());
				end
				while (cand_bytes.size() > 0 && cand_bytes[0] != cur_header) begin
					void'(cand_bytes.pop_front());
				end
			end
		end else if (queued_bytes.size() > 0) begin
			w = queued_bytes.pop_front();
			active = 1'b1;
			r.out_valid = 1'b1;
			r.out_byte = w[BYTE_W-1:0];
			r.out_last = w[BYTE_W];
		end
		r.queue_level = QLEVEL_W'(queued_bytes.size());
		return r;
	endfunction

	// Entered and left at a falling edge; valid stays up for a following transaction.
	task automatic send_item(input req_item_t it, input bit typed, input rsp_item_t typed_want);
		bit active;
		rsp_item_t want;
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		want = deframe_step(it, active);
		due_outputs.push_back(typed ? typed_want : want);
		if (active) effective_items++;
		if (want.frame_dropped) drops_seen++;
		@(negedge clk);
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		send_item(req_item_t'{FUNC_PUSH, b}, 1'b0, NO_RESULT);
	endtask

	task automatic pull_byte();
		send_item(req_item_t'{FUNC_PULL, BYTE_W'($urandom)}, 1'b0, NO_RESULT);
	endtask

	task automatic set_markers(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] tl);
		req_ch.valid <= 1'b0;
		while (due_outputs.size() != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_HEADER;
		cfg_wdata <= hdr;
		@(negedge clk);
		cfg_idx <= CFG_TAIL;
		cfg_wdata <= tl;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_header = hdr;
		cur_tail = tl;
	endtask

	task automatic send_frame(input int plen, input bit bad_tail, input int pull_pct);
		logic [BYTE_W-1:0] fb;
		for (int i = 0; i < plen + FRAME_OVH; i++) begin
			if (i == 0) begin
				fb = cur_header;
			end else if (i == LEN_OFS) begin
				fb = BYTE_W'(plen);
			end else if (i == plen + FRAME_OVH - 1) begin
				fb = bad_tail ? cur_tail ^ (8'h01 << $urandom_range(7)) : cur_tail;
			end else if ($urandom_range(19) == 0) begin
				// stray header inside the frame body
				fb = cur_header;
			end else begin
				fb = BYTE_W'($urandom);
			end
			push_byte(fb);
			if ($urandom_range(99) < pull_pct) pull_byte();
		end
	endtask

	// In fill mode send longest frames without pulls until the queue overflows.
	task automatic run_phase(input int budget, input int pull_pct, input bit fill);
		int first;
		int drops_before;
		int r;
		int plen;
		first = effective_items;
		drops_before = drops_seen;
		while (effective_items - first < budget && !(fill && drops_seen != drops_before)) begin
			r = $urandom_range(99);
			if (fill || r < 90 - pull_pct) begin
				plen = $urandom_range(12);
				if (fill) begin
					plen = 255;
				end else if ($urandom_range(99) < 4) begin
					plen = 255;
				end else if ($urandom_range(99) < 8) begin
					plen = $urandom_range(255);
				end
				send_frame(plen, !fill && $urandom_range(99) < 15, fill ? 0 : pull_pct / 4);
			end else if (r < 90) begin
				repeat ($urandom_range(16, 1)) pull_byte();
			end else begin
				repeat ($urandom_range(4, 1)) push_byte(BYTE_W'($urandom));
			end
		end
	endtask

	always @(negedge clk) begin
		rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);
	end

	// Hold off the result side long enough for the block to back up into its input.
	initial begin : long_hold
		wait (random_started);
		repeat (40) @(negedge clk);
		hold_rsp <= 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_rsp <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_outputs.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN) begin
					$display("%0t: result transaction with nothing expected: %p", $realtime,
						rsp_ch.data);
				end
			end else begin
				oldest_due = due_outputs.pop_front();
				if (rsp_ch.data.out_valid !== oldest_due.out_valid ||
					rsp_ch.data.out_byte !== oldest_due.out_byte ||
					rsp_ch.data.out_last !== oldest_due.out_last ||
					rsp_ch.data.frame_dropped !== oldest_due.frame_dropped ||
					rsp_ch.data.queue_level !== oldest_due.queue_level) begin
					errors++;
					if (errors <= MAX_SHOWN) begin
						$display("%0t: mismatch valid/byte/last/dropped/level", $realtime);
						$display("  expected %b %h %b %b %0d", oldest_due.out_valid,
							oldest_due.out_byte, oldest_due.out_last,
							oldest_due.frame_dropped, oldest_due.queue_level);
						$display("  actual   %b %h %b %b %0d", rsp_ch.data.out_valid,
							rsp_ch.data.out_byte, rsp_ch.data.out_last,
							rsp_ch.data.frame_dropped, rsp_ch.data.queue_level);
					end
				end
			end
		end
	end

	initial begin : watchdog
		#4_000_000;
		$display("header_length_tail_deframer_test: done, errors");
		$finish;
	end

	initial begin : stimulus
		dir_row_t rows [24];
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_HEADER;
		cfg_wdata = '0;
		cur_header = HDR_RESET;
		cur_tail = TAIL_RESET;
		rows = '{
			'{FUNC_PULL, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd0}},
			'{FUNC_PUSH, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd0}},
			'{FUNC_PUSH, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd0}},
			'{FUNC_PUSH, HDR_RESET, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd0}},
			'{FUNC_PUSH, 8'h01, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'h02, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'hFE, 1'b0, NO_RESULT},
			'{FUNC_PUSH, TAIL_RESET, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd6}},
			'{FUNC_PULL, 8'h00, 1'b1, '{1'b1, HDR_RESET, 1'b0, 1'b0, 11'd5}},
			'{FUNC_PULL, 8'hFF, 1'b0, NO_RESULT},
			'{FUNC_PULL, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PULL, 8'hFF, 1'b0, NO_RESULT},
			'{FUNC_PULL, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PULL, 8'hFF, 1'b1, '{1'b1, TAIL_RESET, 1'b1, 1'b0, 11'd0}},
			'{FUNC_PULL, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd0}},
			// wrong tail, then the rescan finds the second header
			'{FUNC_PUSH, HDR_RESET, 1'b0, NO_RESULT},
			'{FUNC_PUSH, HDR_RESET, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PUSH, 8'h00, 1'b0, NO_RESULT},
			'{FUNC_PUSH, TAIL_RESET, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 11'd6}},
			'{FUNC_PULL, 8'hFF, 1'b1, '{1'b1, HDR_RESET, 1'b0, 1'b0, 11'd5}}
		};
		req_idle_pct = 10;
		rsp_idle_pct = 72;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			send_item(req_item_t'{rows[i].func, rows[i].data}, rows[i].typed, rows[i].want);
		end

		random_started = 1'b1;
		set_markers(8'h00, 8'hFF);
		run_phase(30, 10, 1'b0);
		set_markers(8'hFF, 8'h00);
		run_phase(30, 10, 1'b0);
		req_idle_pct = 72;
		rsp_idle_pct = 10;
		set_markers(HDR_RESET, TAIL_RESET);
		run_phase(1000, 0, 1'b1);
		set_markers(BYTE_W'($urandom), BYTE_W'($urandom));
		run_phase(25, 60, 1'b0);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		// header and tail share one value
		set_markers(8'h5A, 8'h5A);
		run_phase(25, 35, 1'b0);

		req_ch.valid <= 1'b0;
		while (due_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("header_length_tail_deframer_test: done, clean");
		end else begin
			$display("header_length_tail_deframer_test: done, errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/hltd_pkg.sv
hw/rtl/hltd_stream_if.sv
hw/rtl/hltd_ram.sv
hw/rtl/hltd_seq.sv
hw/rtl/header_length_tail_deframer.sv
sim/header_length_tail_deframer_test.sv
